// ----- sv/hvcc_to_annexb_converter_top_defines.svh -----
// Assertion macros shared by the checker files of the converter.
`ifndef HVCC_TO_ANNEXB_CONVERTER_TOP_DEFINES_SVH
`define HVCC_TO_ANNEXB_CONVERTER_TOP_DEFINES_SVH

// Clocked check, switched off while reset is asserted.
`define H2AB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked check that also holds while reset is asserted.
`define H2AB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/h2ab_pkg.sv -----
// Types and constants shared by the hvcC to Annex-B converter.
package h2ab_pkg;

  localparam int unsigned HeaderBytesDef = 22;
  localparam int unsigned QueueDepthDef  = 4;
  localparam int unsigned StartCodeLen   = 4;

  localparam logic [7:0] START_CODE [StartCodeLen] = '{8'h00, 8'h00, 8'h00, 8'h01};

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_ARRCNT  = 3'd1,
    PH_ARRTYPE = 3'd2,
    PH_NALCNT  = 3'd3,
    PH_NALLEN  = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_DONE    = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    ST_DATA      = 2'd0,
    ST_DONE      = 2'd1,
    ST_MALFORMED = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] record_byte;
    logic       record_end;
  } rec_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_e    status;
    logic       run_last;
  } rec_out_t;

  // Work handed from the parser to the emitter.
  typedef struct packed {
    logic       start;
    logic       data;
    logic       fin;
    status_e    st;
    logic [7:0] dbyte;
  } cmd_t;

endpackage

// ----- sv/h2ab_front.sv -----
// Record parser: walks the hvcC structure and issues emit commands.
module h2ab_front #(
  parameter int unsigned HEADER_BYTES = h2ab_pkg::HeaderBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  h2ab_pkg::rec_in_t in_data_i,
  input  logic             push_ready_i,
  output logic             push_o,
  output h2ab_pkg::cmd_t   cmd_o
);
  import h2ab_pkg::*;

  localparam int unsigned HW = $clog2(HEADER_BYTES + 1);

  phase_e        phase_q, phase_d;
  logic [HW-1:0] hdr_q, hdr_d;
  logic [7:0]    arrays_q, arrays_d;
  logic [15:0]   nals_q, nals_d;
  logic [15:0]   pay_q, pay_d;
  logic [7:0]    hi_q, hi_d;
  logic          second_q, second_d;
  logic [15:0]   word;
  logic [15:0]   nals_n;
  logic          nal_fin;
  logic          accept;
  cmd_t          cmd;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign word       = {hi_q, in_data_i.record_byte};

  always_comb begin
    phase_d  = phase_q;
    hdr_d    = hdr_q;
    arrays_d = arrays_q;
    nals_d   = nals_q;
    pay_d    = pay_q;
    hi_d     = hi_q;
    second_d = second_q;
    nal_fin  = 1'b0;
    nals_n   = nals_q;
    cmd      = '0;
    cmd.st   = ST_DATA;
    unique case (phase_q)
      PH_HEADER: begin
        hdr_d = hdr_q + HW'(1);
        if (hdr_d >= HW'(HEADER_BYTES)) phase_d = PH_ARRCNT;
      end
      PH_ARRCNT: begin
        arrays_d = in_data_i.record_byte;
        phase_d  = (in_data_i.record_byte == 8'd0) ? PH_DONE : PH_ARRTYPE;
      end
      PH_ARRTYPE: begin
        second_d = 1'b0;
        phase_d  = PH_NALCNT;
      end
      PH_NALCNT: begin
        if (!second_q) begin
          hi_d     = in_data_i.record_byte;
          second_d = 1'b1;
        end else begin
          second_d = 1'b0;
          nals_d   = word;
          arrays_d = arrays_q - 8'd1;
          if (word != 16'd0) phase_d = PH_NALLEN;
          else if (arrays_d != 8'd0) phase_d = PH_ARRTYPE;
          else phase_d = PH_DONE;
        end
      end
      PH_NALLEN: begin
        if (!second_q) begin
          hi_d     = in_data_i.record_byte;
          second_d = 1'b1;
        end else begin
          second_d  = 1'b0;
          cmd.start = 1'b1;
          pay_d     = word;
          if (word == 16'd0) nal_fin = 1'b1;
          else phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        cmd.data  = 1'b1;
        cmd.dbyte = in_data_i.record_byte;
        pay_d     = pay_q - 16'd1;
        if (pay_d == 16'd0) nal_fin = 1'b1;
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase

    // finish a NAL: next NAL, next array or done
    if (nal_fin) begin
      if (nals_q != 16'd0) nals_n = nals_q - 16'd1;
      nals_d   = nals_n;
      second_d = 1'b0;
      if (nals_n != 16'd0) phase_d = PH_NALLEN;
      else if (arrays_q != 8'd0) phase_d = PH_ARRTYPE;
      else phase_d = PH_DONE;
    end

    if (in_data_i.record_end) begin
      cmd.fin  = 1'b1;
      cmd.st   = (phase_d == PH_DONE) ? ST_DONE : ST_MALFORMED;
      phase_d  = PH_HEADER;
      hdr_d    = '0;
      arrays_d = '0;
      nals_d   = '0;
      pay_d    = '0;
      hi_d     = '0;
      second_d = 1'b0;
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept && (cmd.start || cmd.data || cmd.fin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      hdr_q    <= '0;
      arrays_q <= '0;
      nals_q   <= '0;
      pay_q    <= '0;
      hi_q     <= '0;
      second_q <= 1'b0;
    end else if (accept) begin
      phase_q  <= phase_d;
      hdr_q    <= hdr_d;
      arrays_q <= arrays_d;
      nals_q   <= nals_d;
      pay_q    <= pay_d;
      hi_q     <= hi_d;
      second_q <= second_d;
    end
  end

endmodule

// ----- sv/h2ab_queue.sv -----
// Command queue between the parser and the emitter.
module h2ab_queue #(
  parameter int unsigned DEPTH = h2ab_pkg::QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  h2ab_pkg::cmd_t push_data_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output h2ab_pkg::cmd_t pop_data_o
);
  import h2ab_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign ready_o    = (cnt_q != CW'(DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      if (do_pop) rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + CW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule

// ----- sv/h2ab_back.sv -----
// Emitter: expands each command into start code, data and status words.
module h2ab_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  h2ab_pkg::cmd_t    cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output h2ab_pkg::rec_out_t out_data_o
);
  import h2ab_pkg::*;

  logic [2:0] idx_q;
  logic [2:0] n_data;
  logic [2:0] total;
  logic       is_last;
  logic       fire;
  rec_out_t   res;

  assign n_data  = cmd_i.start ? 3'(StartCodeLen) : (cmd_i.data ? 3'd1 : 3'd0);
  assign total   = n_data + {2'b00, cmd_i.fin};
  assign is_last = (idx_q == total - 3'd1);

  always_comb begin
    res          = '0;
    res.status   = ST_DATA;
    res.run_last = is_last;
    if (idx_q < n_data) begin
      res.out_byte = cmd_i.start ? START_CODE[idx_q[1:0]] : cmd_i.dbyte;
    end else begin
      res.status = cmd_i.st;
    end
  end

  assign out_valid_o = cmd_valid_i;
  assign out_data_o  = res;
  assign fire        = out_valid_o && out_ready_i;
  assign pop_o       = fire && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (fire) begin
      idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
    end
  end

endmodule

// ----- sv/hvcc_to_annexb_converter_top.sv -----
// hvcC to Annex-B converter: takes a configuration record one byte a word and returns
// the parameter-set NAL units with 00 00 00 01 start codes, then a done or malformed
// status on the record's last byte. The parser takes one byte every cycle while the
// queue has room; each word that completes a NAL length produces four start-code
// words, so the output port, at one word per cycle while out_ready_i is high, sets
// the sustained rate, and a queue of QUEUE_DEPTH commands lets the parser keep
// accepting while start codes drain. Bytes after a complete parse yield no data word.
module hvcc_to_annexb_converter_top #(
  parameter int unsigned HEADER_BYTES = h2ab_pkg::HeaderBytesDef,
  parameter int unsigned QUEUE_DEPTH  = h2ab_pkg::QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  h2ab_pkg::rec_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output h2ab_pkg::rec_out_t out_data_o
);
  import h2ab_pkg::*;

  logic push, push_ready, pop, cmd_valid;
  cmd_t push_cmd, head_cmd;

  h2ab_front #(.HEADER_BYTES(HEADER_BYTES)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_ready_i (push_ready),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  h2ab_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .ready_o     (push_ready),
    .pop_i       (pop),
    .valid_o     (cmd_valid),
    .pop_data_o  (head_cmd)
  );

  h2ab_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- sv/h2ab_checker.sv -----
// Port-level checks for the converter and their binding to the top level.
`include "hvcc_to_annexb_converter_top_defines.svh"

module h2ab_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input h2ab_pkg::rec_out_t out_data_i
);
  import h2ab_pkg::*;

  `H2AB_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !out_valid_i, "output word during reset")
  `H2AB_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i), "stalled output word changed")
  `H2AB_ASSERT(a_status_zero_byte, out_valid_i && out_data_i.status != ST_DATA |-> out_data_i.out_byte == 8'd0, "status word with non-zero byte")
  `H2AB_ASSERT(a_status_last, out_valid_i && out_data_i.status != ST_DATA |-> out_data_i.run_last, "status word not last of its run")

endmodule

bind hvcc_to_annexb_converter_top h2ab_checker u_h2ab_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
